// ===== sv/swts_pkg.sv =====
// Shared types, register indexes, widths and reset values for the tone sequencer.
package swts_pkg;

  localparam int SAMPLE_WIDTH_DEF = 8;

  localparam int TONE_W  = 16;
  localparam int RATE_W  = 18;
  localparam int SPE_W   = 12;
  localparam int GATE_W  = 16;
  localparam int LEVEL_W = 8;
  localparam int IDX_W   = 3;
  localparam int INTV_W  = 18;
  // half the sample rate, and the magnitude of a positive tone
  localparam int DVD_W   = RATE_W - 1;
  localparam int DVS_W   = TONE_W - 1;

  localparam logic [IDX_W-1:0] REG_SAMPLE_RATE       = 3'd0;
  localparam logic [IDX_W-1:0] REG_SAMPLES_PER_ENTRY = 3'd1;
  localparam logic [IDX_W-1:0] REG_GATE_PERIOD       = 3'd2;
  localparam logic [IDX_W-1:0] REG_SILENCE_LEVEL     = 3'd3;
  localparam logic [IDX_W-1:0] REG_AMPLITUDE         = 3'd4;

  localparam logic [RATE_W-1:0]  RST_SAMPLE_RATE       = 18'd44100;
  localparam logic [SPE_W-1:0]   RST_SAMPLES_PER_ENTRY = 12'd320;
  localparam logic [GATE_W-1:0]  RST_GATE_PERIOD       = 16'd1;
  localparam logic [LEVEL_W-1:0] RST_SILENCE_LEVEL     = 8'd128;
  localparam logic [LEVEL_W-1:0] RST_AMPLITUDE         = 8'd32;

  localparam logic [TONE_W-1:0] TONE_END = 16'hFFFF;

  // tone classes, decided at the front
  localparam logic [1:0] CLS_END  = 2'd0;
  localparam logic [1:0] CLS_ZERO = 2'd1;
  localparam logic [1:0] CLS_POS  = 2'd2;
  localparam logic [1:0] CLS_NEG  = 2'd3;

  typedef struct packed {
    logic [RATE_W-1:0]  sample_rate;
    logic [SPE_W-1:0]   samples_per_entry;
    logic [GATE_W-1:0]  gate_period;
    logic [LEVEL_W-1:0] silence_level;
    logic [LEVEL_W-1:0] amplitude;
  } swts_cfg_t;

  typedef struct packed {
    logic             restart;
    logic [1:0]       cls;
    logic [DVS_W-1:0] mag;
  } swts_req_t;

endpackage

// ===== sv/swts_front.sv =====
// Front end: classify incoming requests and hold them in a two-entry queue.
module swts_front import swts_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [TONE_W-1:0] in_tone,
  input  logic                     in_restart,
  input  logic                     in_push,
  output logic                     in_full,
  output swts_req_t                req,
  output logic                     req_valid,
  input  logic                     req_pop
);

  localparam logic [1:0] Q_FULL = 2'd2;

  swts_req_t  q_r [2];
  swts_req_t  req_in;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  always_comb begin
    req_in.restart = in_restart;
    req_in.mag     = in_tone[DVS_W-1:0];
    priority if (in_tone == TONE_END) begin
      req_in.cls = CLS_END;
    end else if (in_tone == '0) begin
      req_in.cls = CLS_ZERO;
    end else if (in_tone[TONE_W-1]) begin
      req_in.cls = CLS_NEG;
    end else begin
      req_in.cls = CLS_POS;
    end
  end

  assign in_full   = (cnt_r == Q_FULL);
  assign req_valid = (cnt_r != 2'd0);
  assign req       = q_r[rd_ptr_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = req_pop && req_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= req_in;
    end
  end

endmodule

// ===== sv/swts_div.sv =====
// Restoring divider, one quotient bit per cycle, for the toggle interval.
module swts_div import swts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int             CNT_W     = $clog2(DVD_W + 1);
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DVD_W);

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] diff;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DVD_W-1]};
    diff     = {1'b0, rem_sh} - {2'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = DIV_STEPS;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // subtract when the shifted remainder covers the divisor
      if (!diff[DVS_W+1]) begin
        rem_nxt = diff[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== sv/swts_back.sv =====
// Back end: sequence one request at a time through the tone state and a result queue.
module swts_back import swts_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  swts_cfg_t               cfg,
  input  swts_req_t               req,
  input  logic                    req_valid,
  output logic                    req_pop,
  output logic [SAMPLE_WIDTH-1:0] out_sample,
  output logic                    out_last_of_entry,
  output logic                    out_sound_done,
  output logic                    out_empty,
  input  logic                    out_pop
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] OQ_FULL = 2'd2;

  logic [1:0]        state_r, state_nxt;
  swts_req_t         cur_r, cur_nxt;
  logic [SPE_W-1:0]  pos_r, pos_nxt;
  logic [GATE_W-1:0] phase_r, phase_nxt;
  logic [SPE_W-1:0]  tcnt_r, tcnt_nxt;
  logic [INTV_W-1:0] intv_r, intv_nxt;
  logic              wave_r, wave_nxt;

  logic [SAMPLE_WIDTH-1:0] oq_sample_r [2];
  logic              oq_last_r [2];
  logic              oq_done_r [2];
  logic              oq_wr_r, oq_rd_r;
  logic [1:0]        oq_cnt_r;
  logic              out_push, out_take;

  logic                    take, need_div, div_start, div_done;
  logic [DVD_W-1:0]        div_q;
  logic [SAMPLE_WIDTH-1:0] res_sample;
  logic                    res_last, res_done;

  logic [SPE_W-1:0]  cnt_eff;
  logic [INTV_W-1:0] intv_eff;
  logic              sounding, wave_eff;
  logic [SPE_W:0]    pos_inc, spe_eff;
  logic [GATE_W:0]   phase_inc, gate_eff;

  assign take      = req_valid && (oq_cnt_r != OQ_FULL);
  assign need_div  = (req.cls == CLS_POS) && (req.restart || (pos_r == '0));
  assign div_start = (state_r == S_IDLE) && take && need_div;

  swts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cfg.sample_rate[RATE_W-1:1]),
    .divisor  (req.mag),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    tcnt_nxt   = tcnt_r;
    intv_nxt   = intv_r;
    wave_nxt   = wave_r;
    req_pop    = 1'b0;
    out_push   = 1'b0;
    res_sample = SAMPLE_WIDTH'(cfg.silence_level);
    res_last   = 1'b0;
    res_done   = 1'b0;

    cnt_eff   = (pos_r == '0) ? '0 : tcnt_r;
    intv_eff  = ((pos_r == '0) && (cur_r.cls != CLS_POS)) ? '0 : intv_r;
    sounding  = (cur_r.cls != CLS_ZERO) && (phase_r == '0);
    wave_eff  = wave_r;
    pos_inc   = {1'b0, pos_r} + (SPE_W+1)'(1);
    spe_eff   = (cfg.samples_per_entry == '0) ? (SPE_W+1)'(1)
                                              : {1'b0, cfg.samples_per_entry};
    phase_inc = {1'b0, phase_r} + (GATE_W+1)'(1);
    gate_eff  = (cfg.gate_period == '0) ? (GATE_W+1)'(1) : {1'b0, cfg.gate_period};

    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          req_pop = 1'b1;
          cur_nxt = req;
          // restart clears the sound state before the tick is handled
          if (req.restart) begin
            pos_nxt   = '0;
            phase_nxt = '0;
            tcnt_nxt  = '0;
            intv_nxt  = '0;
            wave_nxt  = 1'b1;
          end
          state_nxt = need_div ? S_DIV : S_EXEC;
        end
      end
      S_DIV: begin
        if (div_done) begin
          intv_nxt  = INTV_W'(div_q);
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        out_push  = 1'b1;
        state_nxt = S_IDLE;
        if (cur_r.cls == CLS_END) begin
          res_done = 1'b1;
        end else begin
          intv_nxt = intv_eff;
          if (sounding) begin
            if (INTV_W'(cnt_eff) == intv_eff) begin
              wave_eff = ~wave_r;
              cnt_eff  = '0;
            end
            res_sample = wave_eff ? SAMPLE_WIDTH'(cfg.amplitude) : '0;
          end
          wave_nxt = wave_eff;
          tcnt_nxt = cnt_eff + SPE_W'(1);
          res_last = (pos_inc >= spe_eff);
          if (res_last) begin
            pos_nxt   = '0;
            phase_nxt = (phase_inc >= gate_eff) ? '0 : phase_inc[GATE_W-1:0];
          end else begin
            pos_nxt = pos_inc[SPE_W-1:0];
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      phase_r <= '0;
      tcnt_r  <= '0;
      intv_r  <= '0;
      wave_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      tcnt_r  <= tcnt_nxt;
      intv_r  <= intv_nxt;
      wave_r  <= wave_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // result queue
  assign out_empty         = (oq_cnt_r == 2'd0);
  assign out_take          = out_pop && !out_empty;
  assign out_sample        = oq_sample_r[oq_rd_r];
  assign out_last_of_entry = oq_last_r[oq_rd_r];
  assign out_sound_done    = oq_done_r[oq_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (out_push) begin
        oq_wr_r <= ~oq_wr_r;
      end
      if (out_take) begin
        oq_rd_r <= ~oq_rd_r;
      end
      oq_cnt_r <= oq_cnt_r + 2'(out_push) - 2'(out_take);
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      oq_sample_r[oq_wr_r] <= res_sample;
      oq_last_r[oq_wr_r]   <= res_last;
      oq_done_r[oq_wr_r]   <= res_done;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> (oq_cnt_r != OQ_FULL))
    else $error("result queue written while full");

  a_div_only_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cur_r.cls == CLS_POS))
    else $error("divide in progress for a tone that is not positive");

  a_div_enters: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (state_r == S_DIV))
    else $error("divider started without waiting for it");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    req_pop |-> (req_valid && (state_r == S_IDLE)))
    else $error("request taken outside idle or from an empty queue");

endmodule

// ===== sv/square_wave_tone_sequencer.sv =====
// Top level: configuration registers, front request queue and back tone sequencer.
// Path: a push enters the front queue, the back end takes it into its current request,
//   and the result goes to the result queue; the first tick of an entry with a positive
//   tone also waits for the 17-step interval divider. The back end handles one request
//   at a time, takes no new one until the last is queued, and shares one serial divider.
// Reset (synchronous, active low): registers return to their defaults, counters clear,
//   polarity goes high, both queues empty. No clearing pass.
module square_wave_tone_sequencer import swts_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // tick requests
  input  logic signed [TONE_W-1:0] in_tone,
  input  logic                     in_restart,
  input  logic                     in_push,
  output logic                     in_full,
  // samples
  output logic [SAMPLE_WIDTH-1:0]  out_sample,
  output logic                     out_last_of_entry,
  output logic                     out_sound_done,
  output logic                     out_empty,
  input  logic                     out_pop,
  // register writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [RATE_W-1:0]        cfg_data
);

  swts_cfg_t cfg_r, cfg_nxt;
  swts_req_t req;
  logic      req_valid, req_pop;

  // The user must write registers only while the block is idle; the block does not enforce it, so always accept.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_SAMPLE_RATE:       cfg_nxt.sample_rate       = cfg_data;
        REG_SAMPLES_PER_ENTRY: cfg_nxt.samples_per_entry = cfg_data[SPE_W-1:0];
        REG_GATE_PERIOD:       cfg_nxt.gate_period       = cfg_data[GATE_W-1:0];
        REG_SILENCE_LEVEL:     cfg_nxt.silence_level     = cfg_data[LEVEL_W-1:0];
        REG_AMPLITUDE:         cfg_nxt.amplitude         = cfg_data[LEVEL_W-1:0];
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_rate       <= RST_SAMPLE_RATE;
      cfg_r.samples_per_entry <= RST_SAMPLES_PER_ENTRY;
      cfg_r.gate_period       <= RST_GATE_PERIOD;
      cfg_r.silence_level     <= RST_SILENCE_LEVEL;
      cfg_r.amplitude         <= RST_AMPLITUDE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: classify each tone (end, silent, positive, other negative) and queue it.
  swts_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tone    (in_tone),
    .in_restart (in_restart),
    .in_push    (in_push),
    .in_full    (in_full),
    .req        (req),
    .req_valid  (req_valid),
    .req_pop    (req_pop)
  );

  // Back: advance entry counters, divide at entry starts, flip polarity, queue samples.
  swts_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .req               (req),
    .req_valid         (req_valid),
    .req_pop           (req_pop),
    .out_sample        (out_sample),
    .out_last_of_entry (out_last_of_entry),
    .out_sound_done    (out_sound_done),
    .out_empty         (out_empty),
    .out_pop           (out_pop)
  );

endmodule

// ===== sim/square_wave_tone_sequencer_tb.sv =====
// Self-checking testbench for the square-wave tone sequencer: directed table, then random phases.
`timescale 1ns / 100ps

module square_wave_tone_sequencer_tb;
  import swts_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 11;
  localparam int NUM_PHASES    = 10;
  localparam int TICKS_PER_PH  = 85;
  localparam int IDLE_PCT      = 15;
  localparam int DRAIN_CYCLES  = 48;      // well past the divide latency
  localparam int HOLD_AT       = 150;     // result count that starts the long sink hold-off
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 500000;

  // one result of the block, as the sink sees it
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               last_of_entry;
    logic               sound_done;
  } tick_result_t;

  typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

  // one row of the directed table: a tick request or a register write
  typedef struct packed {
    row_kind_t          kind;
    logic [IDX_W-1:0]   idx;
    logic [RATE_W-1:0]  data;
    logic [TONE_W-1:0]  tone;
    logic               restart;
    logic               typed;
    tick_result_t       want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic signed [TONE_W-1:0] in_tone = '0;
  logic                     in_restart = 1'b0;
  logic                     in_push = 1'b0;
  logic                     in_full;
  logic [LEVEL_W-1:0]       out_sample;
  logic                     out_last_of_entry;
  logic                     out_sound_done;
  logic                     out_empty;
  logic                     out_pop = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [IDX_W-1:0]         cfg_index = '0;
  logic [RATE_W-1:0]        cfg_data = '0;

  always #CLK_HALF clk = ~clk;

  square_wave_tone_sequencer u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_tone           (in_tone),
    .in_restart        (in_restart),
    .in_push           (in_push),
    .in_full           (in_full),
    .out_sample        (out_sample),
    .out_last_of_entry (out_last_of_entry),
    .out_sound_done    (out_sound_done),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Tone predictor: own copy of the registers and the sequencing state.
  // ---------------------------------------------------------------------------
  logic [RATE_W-1:0]  rate_q;
  logic [SPE_W-1:0]   spe_q;
  logic [GATE_W-1:0]  gate_q;
  logic [LEVEL_W-1:0] silence_q;
  logic [LEVEL_W-1:0] amp_q;

  logic [SPE_W-1:0]   pos_q;       // tick index within the entry
  logic [GATE_W-1:0]  phase_q;     // entry index modulo the gate period
  logic [11:0]        tcount_q;    // ticks since entry start or last flip
  logic [INTV_W-1:0]  tintv_q;     // flip interval of the current entry
  logic               high_q;      // polarity, high means the amplitude level

  tick_result_t pending_samples[$];  // expected samples, oldest first
  plan_row_t    plan[$];             // directed table, walked in order
  int           mismatches = 0;
  int           results_seen = 0;
  int           ticks_sent = 0;
  int           cycle_count = 0;

  function automatic void clear_sound();
    pos_q    = '0;
    phase_q  = '0;
    tcount_q = '0;
    tintv_q  = '0;
    high_q   = 1'b1;
  endfunction

  function automatic void reset_registers();
    rate_q    = RST_SAMPLE_RATE;
    spe_q     = RST_SAMPLES_PER_ENTRY;
    gate_q    = RST_GATE_PERIOD;
    silence_q = RST_SILENCE_LEVEL;
    amp_q     = RST_AMPLITUDE;
    clear_sound();
  endfunction

  function automatic void apply_register(logic [IDX_W-1:0] idx, logic [RATE_W-1:0] data);
    case (idx)
      REG_SAMPLE_RATE:       rate_q    = data;
      REG_SAMPLES_PER_ENTRY: spe_q     = data[SPE_W-1:0];
      REG_GATE_PERIOD:       gate_q    = data[GATE_W-1:0];
      REG_SILENCE_LEVEL:     silence_q = data[LEVEL_W-1:0];
      REG_AMPLITUDE:         amp_q     = data[LEVEL_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the sequencer by one tick and return the sample it yields.
  function automatic tick_result_t next_tone_sample(logic [TONE_W-1:0] tone, logic restart);
    tick_result_t r;
    logic [SPE_W-1:0]  spe_eff;
    logic [GATE_W-1:0] gate_eff;
    spe_eff  = (spe_q == '0) ? SPE_W'(1) : spe_q;
    gate_eff = (gate_q == '0) ? GATE_W'(1) : gate_q;
    r = '0;
    if (restart)
      clear_sound();
    // end of sound: silence, flag it, touch nothing else
    if (tone == TONE_END) begin
      r.level      = silence_q;
      r.sound_done = 1'b1;
      return r;
    end
    // entry start: compute the flip interval, zero for silent or negative tones
    if (pos_q == '0) begin
      if (tone != '0 && !tone[TONE_W-1])
        tintv_q = INTV_W'({1'b0, rate_q[RATE_W-1:1]} / RATE_W'(tone));
      else
        tintv_q = '0;
      tcount_q = '0;
    end
    if (tone == '0 || phase_q != '0) begin
      r.level = silence_q;
    end else begin
      if (INTV_W'(tcount_q) == tintv_q) begin
        high_q   = ~high_q;
        tcount_q = '0;
      end
      r.level = high_q ? amp_q : '0;
    end
    tcount_q = tcount_q + 12'd1;
    r.last_of_entry = ({1'b0, pos_q} + 13'd1) >= {1'b0, spe_eff};
    if (r.last_of_entry) begin
      pos_q = '0;
      if ({1'b0, phase_q} + 17'd1 >= {1'b0, gate_eff})
        phase_q = '0;
      else
        phase_q = phase_q + GATE_W'(1);
    end else begin
      pos_q = pos_q + SPE_W'(1);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table builders
  // ---------------------------------------------------------------------------
  function automatic plan_row_t tick_row(logic [TONE_W-1:0] tone, logic restart);
    plan_row_t p;
    p = '0;
    p.kind    = ROW_TICK;
    p.tone    = tone;
    p.restart = restart;
    return p;
  endfunction

  function automatic plan_row_t tick_want(logic [TONE_W-1:0] tone, logic restart,
                                          logic [LEVEL_W-1:0] level, logic last, logic done);
    plan_row_t p;
    p = tick_row(tone, restart);
    p.typed = 1'b1;
    p.want  = '{level: level, last_of_entry: last, sound_done: done};
    return p;
  endfunction

  function automatic plan_row_t reg_row(logic [IDX_W-1:0] idx, logic [RATE_W-1:0] data);
    plan_row_t p;
    p = '0;
    p.kind = ROW_REG;
    p.idx  = idx;
    p.data = data;
    return p;
  endfunction

  // Append one row to the end of the directed table.
  function automatic void add_row(plan_row_t p);
    plan.insert(plan.size(), p);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one tick request, idling at random first; leave push high after acceptance.
  task automatic offer_tick(input logic [TONE_W-1:0] tone, input logic restart,
                            input logic typed, input tick_result_t want);
    tick_result_t predicted;
    // keep the sender busy without gaps through one stretch of the random part
    while (!(ticks_sent >= 420 && ticks_sent < 540) && $urandom_range(0, 99) < IDLE_PCT) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push    <= 1'b1;
    in_tone    <= tone;
    in_restart <= restart;
    do @(posedge clk); while (in_full);
    predicted = next_tone_sample(tone, restart);
    pending_samples.insert(pending_samples.size(), typed ? want : predicted);
    ticks_sent++;
  endtask

  // Drop push and hold until every expected sample has been popped.
  task automatic wait_drained();
    in_push <= 1'b0;
    while (pending_samples.size() != 0)
      @(posedge clk);
  endtask

  // Write one register once the block is idle; valid stays high for the caller to drop.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [RATE_W-1:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
  endtask

  // ---------------------------------------------------------------------------
  // Sink side: pop at random, with one long hold-off and one stretch without idling,
  // and compare every popped sample with the oldest expectation.
  // ---------------------------------------------------------------------------
  int  hold_left = 0;
  bit  hold_started = 1'b0;

  always @(posedge clk) begin
    tick_result_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        results_seen <= results_seen + 1;
        if (pending_samples.size() == 0) begin
          $error("sample %0d popped with no request pending", out_sample);
          mismatches++;
        end else begin
          want = pending_samples.pop_front();
          if (out_sample !== want.level) begin
            $error("sample: expected %0d, got %0d", want.level, out_sample);
            mismatches++;
          end
          if (out_last_of_entry !== want.last_of_entry) begin
            $error("last_of_entry: expected %0b, got %0b", want.last_of_entry,
                   out_last_of_entry);
            mismatches++;
          end
          if (out_sound_done !== want.sound_done) begin
            $error("sound_done: expected %0b, got %0b", want.sound_done, out_sound_done);
            mismatches++;
          end
        end
      end
      // decide whether to pop at the next edge
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_pop   <= 1'b0;
      end else if (!hold_started && results_seen >= HOLD_AT) begin
        // stall the sink long enough for the block to fill and raise full
        hold_started <= 1'b1;
        hold_left    <= HOLD_CYCLES;
        out_pop      <= 1'b0;
      end else if (results_seen >= 380 && results_seen < 520) begin
        out_pop <= 1'b1;
      end else begin
        out_pop <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: end the run once the cycle count reaches the limit, as a guard against a hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t    row;
    logic [TONE_W-1:0] cur_tone;
    logic [TONE_W-1:0] tone;
    logic         restart;
    int           pick;

    reset_registers();
    cur_tone = TONE_W'(1);

    // Directed table. Typed expectations only where the value is plain from reset
    // defaults or from an extreme; everything else goes through the predictor.
    // end of sound straight after reset
    add_row(tick_want(TONE_END, 1'b0, RST_SILENCE_LEVEL, 1'b0, 1'b1));
    // silent tone with restart
    add_row(tick_want(16'd0, 1'b1, RST_SILENCE_LEVEL, 1'b0, 1'b0));
    // tone change mid-entry keeps the zero interval of the entry start
    add_row(tick_row(16'd1000, 1'b0));
    // most negative tone: zero interval, one flip at the entry start
    add_row(tick_row(16'h8000, 1'b1));
    add_row(tick_row(16'hFFFE, 1'b0));
    // end of sound together with restart
    add_row(tick_row(TONE_END, 1'b1));
    add_row(reg_row(REG_SAMPLES_PER_ENTRY, 18'd1));
    add_row(tick_want(16'd0, 1'b0, RST_SILENCE_LEVEL, 1'b1, 1'b0));
    add_row(reg_row(REG_SILENCE_LEVEL, 18'd255));
    add_row(tick_want(TONE_END, 1'b0, 8'd255, 1'b0, 1'b1));
    add_row(reg_row(REG_AMPLITUDE, 18'd255));
    // tone above half the rate: flips low at the first tick of the entry
    add_row(tick_want(16'd32767, 1'b1, 8'd0, 1'b1, 1'b0));
    add_row(tick_row(16'd32767, 1'b0));
    // zero samples per entry counts as one
    add_row(reg_row(REG_SAMPLES_PER_ENTRY, 18'd0));
    add_row(tick_row(16'd1, 1'b0));
    add_row(tick_row(16'd1, 1'b0));
    // zero gate period counts as one
    add_row(reg_row(REG_SAMPLES_PER_ENTRY, 18'd3));
    add_row(reg_row(REG_GATE_PERIOD, 18'd0));
    add_row(tick_row(16'd5000, 1'b1));
    add_row(tick_row(16'd5000, 1'b0));
    add_row(tick_row(16'd5000, 1'b0));
    // gate period two: every other entry is silent
    add_row(reg_row(REG_GATE_PERIOD, 18'd2));
    for (int i = 0; i < 6; i++)
      add_row(tick_row(16'd4000, 1'b0));
    // largest rate, lowest levels, then zero rate
    add_row(reg_row(REG_SAMPLE_RATE, 18'h3FFFF));
    add_row(reg_row(REG_SILENCE_LEVEL, 18'd0));
    add_row(reg_row(REG_AMPLITUDE, 18'd0));
    add_row(tick_row(16'd1, 1'b1));
    add_row(reg_row(REG_SAMPLE_RATE, 18'd0));
    add_row(tick_row(16'd7, 1'b1));
    // largest entry length and gate period
    add_row(reg_row(REG_GATE_PERIOD, 18'd65535));
    add_row(reg_row(REG_SAMPLES_PER_ENTRY, 18'd4095));
    add_row(tick_row(16'd1, 1'b1));
    add_row(tick_row(16'd1, 1'b0));

    // hold reset, then release it once
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_REG) begin
        write_reg(row.idx, row.data);
      end else begin
        if (cfg_valid)
          cfg_valid <= 1'b0;
        offer_tick(row.tone, row.restart, row.typed, row.want);
      end
    end

    // Random phases: drain, rewrite every register, then stream ticks.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == NUM_PHASES - 1) begin
        // top of every register range
        write_reg(REG_SAMPLE_RATE, 18'h3FFFF);
        write_reg(REG_SAMPLES_PER_ENTRY, 18'd4095);
        write_reg(REG_GATE_PERIOD, 18'd65535);
        write_reg(REG_SILENCE_LEVEL, 18'd255);
        write_reg(REG_AMPLITUDE, 18'd255);
      end else begin
        case ($urandom_range(0, 7))
          0:       write_reg(REG_SAMPLE_RATE, 18'd0);
          1:       write_reg(REG_SAMPLE_RATE, 18'h3FFFF);
          2, 3:    write_reg(REG_SAMPLE_RATE, RATE_W'($urandom_range(8000, 192000)));
          default: write_reg(REG_SAMPLE_RATE, RATE_W'($urandom_range(16, 400)));
        endcase
        case ($urandom_range(0, 7))
          0:       write_reg(REG_SAMPLES_PER_ENTRY, 18'd0);
          1:       write_reg(REG_SAMPLES_PER_ENTRY, 18'd4095);
          2:       write_reg(REG_SAMPLES_PER_ENTRY, RATE_W'($urandom_range(25, 300)));
          default: write_reg(REG_SAMPLES_PER_ENTRY, RATE_W'($urandom_range(1, 24)));
        endcase
        case ($urandom_range(0, 7))
          0:       write_reg(REG_GATE_PERIOD, 18'd0);
          1:       write_reg(REG_GATE_PERIOD, 18'd65535);
          2:       write_reg(REG_GATE_PERIOD, 18'd1);
          default: write_reg(REG_GATE_PERIOD, RATE_W'($urandom_range(1, 4)));
        endcase
        write_reg(REG_SILENCE_LEVEL, RATE_W'($urandom_range(0, 255)));
        write_reg(REG_AMPLITUDE, RATE_W'($urandom_range(0, 255)));
      end
      cfg_valid <= 1'b0;

      for (int n = 0; n < TICKS_PER_PH; n++) begin
        // pick a fresh tone at each entry start, now and then mid-entry as noise
        if (pos_q == '0 || $urandom_range(0, 99) < 4) begin
          pick = $urandom_range(0, 99);
          if (pick < 55)
            cur_tone = TONE_W'($urandom_range(1, 64));
          else if (pick < 67)
            cur_tone = TONE_W'($urandom_range(65, 32767));
          else if (pick < 77)
            cur_tone = '0;
          else if (pick < 85)
            cur_tone = TONE_W'($urandom_range(16'h8000, 16'hFFFE));
          else
            cur_tone = TONE_W'($urandom);
        end
        tone    = ($urandom_range(0, 99) < 3) ? TONE_END : cur_tone;
        restart = ($urandom_range(0, 99) < 4);
        offer_tick(tone, restart, 1'b0, '0);
      end
    end

    // drain, then let the pipeline settle before judging
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_samples.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
